// ----- rtl/swrl_pkg.sv -----
// ============================================================================
// swrl_pkg
// Shared types and constants of the sliding-window rate limiter.
// ============================================================================
package swrl_pkg;

    localparam int MAX_REQ_W   = 7;
    localparam int WINDOW_W    = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 1'd1;

    localparam logic [MAX_REQ_W-1:0] MAX_REQ_RESET = 7'd5;
    localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 32'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_DELIVER
    } ctrl_state_t;

endpackage

// ----- rtl/sliding_window_rate_limiter_top.sv -----
// ============================================================================
// sliding_window_rate_limiter_top
// Sliding-window log rate limiter with configuration registers.
// ============================================================================
// Each input word is one request stamped with now_time. The block first drops
// log entries whose age (now_time minus grant time, modulo 2^TIME_BITS) is
// strictly greater than window_ticks, then grants and logs the request if
// fewer than min(max_requests, MAX_SLOTS) grants remain, and returns one
// result word with granted and the count left in the window. A request with an
// empty log goes straight to the decision; otherwise the head entry is read and
// expired entries are popped until one has not expired or the log is empty;
// the popping loop runs at one log memory read per cycle. Configuration writes
// are always taken and must only be issued while no request is in progress.
module sliding_window_rate_limiter_top
    import swrl_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [TIME_BITS-1:0]   now_time,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   granted,
    output logic [COUNT_OUT_W-1:0] in_window_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    logic [MAX_REQ_W-1:0] max_req_reg;
    logic [WINDOW_W-1:0]  window_reg;
    logic                 cfg_write;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS-1:0] rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_req_reg <= MAX_REQ_RESET;
            window_reg  <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_REQUESTS:
                begin
                    max_req_reg <= cfg_data[MAX_REQ_W-1:0];
                end
                CFG_WINDOW_TICKS:
                begin
                    window_reg <= cfg_data[WINDOW_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    swrl_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .now_time        (now_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .granted         (granted),
        .in_window_count (in_window_count),
        .max_requests    (max_req_reg),
        .window_ticks    (window_reg),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

    swrl_log_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (TIME_BITS),
        .IDX_W (IDX_W)
    ) u_log_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- rtl/swrl_log_mem.sv -----
// ============================================================================
// swrl_log_mem
// Grant time log: one write port and one read port, registered read data.
// ============================================================================
module swrl_log_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int IDX_W = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/swrl_ctrl.sv -----
// ============================================================================
// swrl_ctrl
// Request sequencer: pops expired entries from the log head one per cycle,
// then grants and appends or denies, and holds the result for the output.
// ============================================================================
module swrl_ctrl
    import swrl_pkg::*;
#(
    parameter int MAX_SLOTS = 64,
    parameter int TIME_BITS = 32,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [TIME_BITS-1:0]   now_time,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   granted,
    output logic [COUNT_OUT_W-1:0] in_window_count,
    input  logic [MAX_REQ_W-1:0]   max_requests,
    input  logic [WINDOW_W-1:0]    window_ticks,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [TIME_BITS-1:0]   wr_data,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  logic [TIME_BITS-1:0]   rd_data
);

    localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
    localparam int LIM_W = (CNT_W > MAX_REQ_W) ? CNT_W : MAX_REQ_W;
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    ctrl_state_t                state_reg, state_next;
    logic [TIME_BITS-1:0]       now_reg, now_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       res_granted_reg, res_granted_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_granted_reg, out_granted_next;
    logic [COUNT_OUT_W-1:0]     out_count_reg, out_count_next;

    logic                       accept;
    logic                       expired;
    logic                       grant_ok;
    logic                       out_free;
    logic [TIME_BITS-1:0]       age;
    logic [IDX_W-1:0]           head_inc;
    logic [SUM_W-1:0]           tail_sum;
    logic [SUM_W-1:0]           tail_wrap;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign age      = now_reg - rd_data;
    assign expired  = CMP_W'(age) > CMP_W'(window_ticks);
    assign head_inc = (head_reg == IDX_W'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(MAX_SLOTS)) ? tail_sum - SUM_W'(MAX_SLOTS)
                                                       : tail_sum;

    assign grant_ok = (LIM_W'(count_reg) < LIM_W'(max_requests))
                   && (count_reg < CNT_W'(MAX_SLOTS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg != '0) ? ST_CHECK : ST_DECIDE;
                end
            end
            ST_CHECK:
            begin
                if (!expired || count_reg == CNT_W'(1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next         = now_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        res_granted_next = res_granted_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_granted_next = out_granted_reg;
        out_count_next   = out_count_reg;
        rd_en            = 1'b0;
        rd_addr          = head_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_wrap[IDX_W-1:0];
        wr_data          = now_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next = now_time;
                    rd_en    = (count_reg != '0);
                end
            end
            ST_CHECK:
            begin
                if (expired)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    rd_en      = (count_reg != CNT_W'(1));
                    rd_addr    = head_inc;
                end
            end
            ST_DECIDE:
            begin
                wr_en            = grant_ok;
                count_next       = count_reg + CNT_W'(grant_ok);
                res_granted_next = grant_ok;
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_count_next   = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        res_granted_reg <= res_granted_next;
        out_granted_reg <= out_granted_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid       = out_valid_reg;
    assign granted         = out_granted_reg;
    assign in_window_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SLOTS))
        else $error("Log count exceeds capacity.");

    a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> count_reg != '0)
        else $error("Head check with an empty log.");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("Log read and write in the same cycle.");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Append did not advance the count.");

endmodule
